/* design/integer_matrix_multiply_top_macros.svh */
// Assertion macros used by the integer matrix multiply controller.
`ifndef INTEGER_MATRIX_MULTIPLY_TOP_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_TOP_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define IMM_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The first condition is followed in the next cycle by the second.
`define IMM_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define IMM_ASSERT(label, cond, msg)
`define IMM_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

/* design/imm_pkg.sv */
// Types, codes and helper functions of the integer matrix multiply block.
package imm_pkg;

    localparam int MAX_DIM_DEFAULT = 64;

    localparam int IDX_W   = 6;
    localparam int DATA_W  = 32;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] CMD_WRITE_A = 2'd0;
    localparam logic [1:0] CMD_WRITE_B = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_COUNT = 2'd2;

    typedef struct packed {
        logic [1:0]              command;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [DATA_W-1:0] element_value;
    } cmd_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [DATA_W-1:0] product_sum;
        logic                    last_of_row;
    } res_word_t;

    // Tag that travels with each pair of store reads through the MAC pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_tag_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] sum;
    } mac_res_t;

    // Size registers take 0 as 1 and anything above the limit as the limit.
    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] value,
                                                    input logic [CFG_W-1:0] limit);
        logic [CFG_W-1:0] v;
        v = value;
        if (v == '0)
        begin
            v = CFG_W'(1);
        end
        if (v > limit)
        begin
            v = limit;
        end
        return v;
    endfunction

endpackage

/* design/imm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/imm_mac.sv */
// Multiply-accumulate pipeline fed by the A and B store read ports.
module imm_mac (
    input  logic                         clk,
    input  logic                         rst_n,
    input  imm_pkg::mac_tag_t            tag_in,
    input  logic [imm_pkg::DATA_W-1:0]   a_data,
    input  logic [imm_pkg::DATA_W-1:0]   b_data,
    input  logic                         acc_clr,
    output imm_pkg::mac_res_t            mac_res
);

    import imm_pkg::*;

    mac_tag_t          s1_tag_reg;
    mac_tag_t          s2_tag_reg;
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] acc_reg;
    logic              done_reg;

    // s1 lines up with the registered RAM data, s2 with the product register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_tag_reg <= tag_in;
            s2_tag_reg <= s1_tag_reg;
            if (acc_clr)
            begin
                done_reg <= 1'b0;
            end
            else if (s2_tag_reg.valid && s2_tag_reg.last)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // Only the low 32 bits of the product matter, so signedness drops out.
    always_ff @(posedge clk)
    begin
        if (s1_tag_reg.valid)
        begin
            prod_reg <= DATA_W'(a_data * b_data);
        end
        if (s2_tag_reg.valid)
        begin
            acc_reg <= s2_tag_reg.first ? prod_reg : DATA_W'(acc_reg + prod_reg);
        end
    end

    assign mac_res.done = done_reg;
    assign mac_res.sum  = acc_reg;

endmodule

/* design/imm_ctrl.sv */
// Size registers, store write decode, row sequencer and result register.
`include "integer_matrix_multiply_top_macros.svh"

module imm_ctrl #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    output logic                                 cmd_stall,
    input  imm_pkg::cmd_word_t                   cmd_word,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output imm_pkg::res_word_t                   res_word,
    input  logic                                 cfg_wr_en,
    input  logic [imm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [imm_pkg::CFG_W-1:0]            cfg_data,
    output logic                                 a_we,
    output logic                                 b_we,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   wr_addr,
    output logic [imm_pkg::DATA_W-1:0]           wr_data,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   a_raddr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   b_raddr,
    output imm_pkg::mac_tag_t                    tag_out,
    input  imm_pkg::mac_res_t                    mac_res,
    output logic                                 acc_clr
);

    import imm_pkg::*;

    localparam int ADDR_W     = $clog2(MAX_DIM * MAX_DIM);
    localparam int SIZE_LIMIT = (MAX_DIM < 64) ? MAX_DIM : 64;
    localparam int SIZE_RESET = (SIZE_LIMIT < 32) ? SIZE_LIMIT : 32;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [CFG_W-1:0] row_count_reg;
    logic [CFG_W-1:0] col_count_reg;
    logic [CFG_W-1:0] inner_count_reg;
    logic             res_valid_reg, res_valid_next;
    res_word_t        res_word_reg;

    logic             accept;
    logic             start;
    logic [CFG_W-1:0] row_ext;
    logic [CFG_W-1:0] col_ext;
    logic             k_last;
    logic             j_last;
    logic             res_free;
    logic             res_load;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign row_ext   = {1'b0, cmd_word.row_index};
    assign col_ext   = {1'b0, cmd_word.col_index};

    assign a_we  = accept && (cmd_word.command == CMD_WRITE_A)
                   && (row_ext < row_count_reg) && (col_ext < inner_count_reg);
    assign b_we  = accept && (cmd_word.command == CMD_WRITE_B)
                   && (row_ext < inner_count_reg) && (col_ext < col_count_reg);
    assign start = accept && (cmd_word.command == CMD_COMPUTE)
                   && (row_ext < row_count_reg);

    // Both stores share the row-major slot layout.
    assign wr_addr = ADDR_W'(int'(cmd_word.row_index) * MAX_DIM + int'(cmd_word.col_index));
    assign wr_data = DATA_W'(cmd_word.element_value);
    assign a_raddr = ADDR_W'(int'(row_reg) * MAX_DIM + int'(k_reg));
    assign b_raddr = ADDR_W'(int'(k_reg) * MAX_DIM + int'(j_reg));

    assign k_last   = (CFG_W'({1'b0, k_reg} + 1'b1) == inner_count_reg);
    assign j_last   = (CFG_W'({1'b0, j_reg} + 1'b1) == col_count_reg);
    assign res_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        tag_out    = '0;
        res_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    row_next   = cmd_word.row_index;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                tag_out.valid = 1'b1;
                tag_out.first = (k_reg == '0);
                tag_out.last  = k_last;
                if (k_last)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // Wait for the column sum, then hand it to the result register.
                if (mac_res.done && res_free)
                begin
                    res_load = 1'b1;
                    if (j_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        k_next     = '0;
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign acc_clr = res_load;

    always_comb
    begin
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_stall)
        begin
            res_valid_next = res_valid_reg;
        end
        else
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            row_reg         <= '0;
            j_reg           <= '0;
            k_reg           <= '0;
            res_valid_reg   <= 1'b0;
            row_count_reg   <= CFG_W'(SIZE_RESET);
            col_count_reg   <= CFG_W'(SIZE_RESET);
            inner_count_reg <= CFG_W'(SIZE_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            res_valid_reg <= res_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_ROW_COUNT:
                    begin
                        row_count_reg <= clamp_size(cfg_data, CFG_W'(SIZE_LIMIT));
                    end
                    CFG_COL_COUNT:
                    begin
                        col_count_reg <= clamp_size(cfg_data, CFG_W'(SIZE_LIMIT));
                    end
                    CFG_INNER_COUNT:
                    begin
                        inner_count_reg <= clamp_size(cfg_data, CFG_W'(SIZE_LIMIT));
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_word_reg.out_row     <= row_reg;
            res_word_reg.out_col     <= j_reg;
            res_word_reg.product_sum <= $signed(mac_res.sum);
            res_word_reg.last_of_row <= j_last;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    `IMM_ASSERT(a_k_in_range, state_reg != ST_ISSUE || CFG_W'(k_reg) < inner_count_reg, "inner index past inner_count")
    `IMM_ASSERT(a_j_in_range, state_reg == ST_IDLE || CFG_W'(j_reg) < col_count_reg, "column index past col_count")
    `IMM_ASSERT(a_done_in_drain, !mac_res.done || state_reg == ST_DRAIN, "column sum finished outside drain")
    `IMM_ASSERT(a_write_when_idle, !(a_we || b_we) || state_reg == ST_IDLE, "store write during a row compute")
    `IMM_ASSERT_NEXT(a_load_then_valid, res_load, res_valid_reg, "loaded result word not presented")

endmodule

/* design/integer_matrix_multiply_top.sv */
// Top level of the integer matrix multiply block: stores, sequencer and MAC.
//
//   channel   direction  handshake                   word
//   cmd       in         cmd_valid / cmd_stall       cmd_word (imm_pkg::cmd_word_t)
//   res       out        res_valid / res_stall       res_word (imm_pkg::res_word_t)
//   cfg       in         cfg_wr_en                   cfg_index, cfg_data
//
// One MAC unit takes one product per cycle within a column from the single read port of
// each store, and each column drains a three-stage pipeline. Reset clears control registers
// and sets the size registers to SIZE_RESET; store contents are undefined until written.
// A stall on the result side holds one word in the output register and pauses the sequencer
// before the next column; the command side is stalled for the whole row compute.
module integer_matrix_multiply_top #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  imm_pkg::cmd_word_t            cmd_word,
    output logic                          res_valid,
    input  logic                          res_stall,
    output imm_pkg::res_word_t            res_word,
    input  logic                          cfg_wr_en,
    input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [imm_pkg::CFG_W-1:0]     cfg_data
);

    import imm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    logic              a_we;
    logic              b_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [ADDR_W-1:0] a_raddr;
    logic [ADDR_W-1:0] b_raddr;
    logic [DATA_W-1:0] a_rdata;
    logic [DATA_W-1:0] b_rdata;
    mac_tag_t          mac_tag;
    mac_res_t          mac_res;
    logic              acc_clr;

    imm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .a_we      (a_we),
        .b_we      (b_we),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .a_raddr   (a_raddr),
        .b_raddr   (b_raddr),
        .tag_out   (mac_tag),
        .mac_res   (mac_res),
        .acc_clr   (acc_clr)
    );

    imm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    imm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_b_store (
        .clk   (clk),
        .we    (b_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    imm_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (mac_tag),
        .a_data  (a_rdata),
        .b_data  (b_rdata),
        .acc_clr (acc_clr),
        .mac_res (mac_res)
    );

endmodule
